### src/prime_lister_trial_division_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the prime lister
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PRIME_LISTER_TRIAL_DIVISION_UNIT_ASSERT_SVH
`define PRIME_LISTER_TRIAL_DIVISION_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PLTD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PLTD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/pltd_pkg.sv
// ----------------------------------------------------------------------------
// pltd_pkg
// Types and constants shared by the prime lister modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pltd_pkg;

  localparam int unsigned CAND_W = 8;
  localparam int unsigned MULT_W = CAND_W + 1;
  localparam int unsigned LIM_W  = 16;

  localparam logic [LIM_W-1:0]  MAX_LIMIT   = 16'd255;
  localparam logic [CAND_W-1:0] FIRST_PRIME = 8'd2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_TEST  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_SPARE = 4'b1000
  } state_e;

  typedef struct packed {
    logic load;
    logic add_div;
    logic next_div;
    logic next_cand;
    logic take_prime;
    logic emit_final;
  } cmd_t;

  typedef struct packed {
    logic lim_lt2;
    logic div_eq_cand;
    logic mult_eq_cand;
    logic mult_gt_cand;
    logic cand_eq_lim;
  } status_t;

endpackage

### src/pltd_ctrl.sv
// ----------------------------------------------------------------------------
// pltd_ctrl
// Sequencer for candidate and divisor iteration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pltd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  pltd_pkg::status_t status_i,
  output pltd_pkg::cmd_t    cmd_o,
  output logic             busy_o
);
  import pltd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_TEST;
        end
      end
      ST_TEST: begin
        if (status_i.lim_lt2) begin
          state_d = ST_FLUSH;
        end else if (status_i.div_eq_cand) begin
          cmd_o.take_prime = 1'b1;
          if (status_i.cand_eq_lim) state_d = ST_FLUSH;
          else cmd_o.next_cand = 1'b1;
        end else if (status_i.mult_eq_cand) begin
          if (status_i.cand_eq_lim) state_d = ST_FLUSH;
          else cmd_o.next_cand = 1'b1;
        end else if (status_i.mult_gt_cand) begin
          cmd_o.next_div = 1'b1;
        end else begin
          cmd_o.add_div = 1'b1;
        end
      end
      ST_FLUSH: begin
        cmd_o.emit_final = 1'b1;
        state_d          = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

### src/pltd_dp.sv
// ----------------------------------------------------------------------------
// pltd_dp
// Candidate, divisor and multiple registers; pending prime and result regs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pltd_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [pltd_pkg::CAND_W-1:0]   limit_i,
  input  pltd_pkg::cmd_t                cmd_i,
  output pltd_pkg::status_t             status_o,
  output logic                          result_valid_o,
  output logic [pltd_pkg::CAND_W-1:0]   prime_o,
  output logic                          found_o,
  output logic                          last_o
);
  import pltd_pkg::*;

  logic [CAND_W-1:0] lim_q, cand_q, div_q, pend_q, prime_q;
  logic [MULT_W-1:0] mult_q;
  logic              pend_v_q, valid_q, found_q, last_q;
  logic [CAND_W-1:0] lim_sat, div_inc;
  logic [MULT_W-1:0] cand_ext;

  assign lim_sat  = ({{(LIM_W-CAND_W){1'b0}}, limit_i} > MAX_LIMIT) ?
                    MAX_LIMIT[CAND_W-1:0] : limit_i;
  assign div_inc  = div_q + 1'b1;
  assign cand_ext = {1'b0, cand_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lim_q  <= lim_sat;
      cand_q <= FIRST_PRIME;
      div_q  <= FIRST_PRIME;
      mult_q <= {1'b0, FIRST_PRIME};
    end else if (cmd_i.next_cand) begin
      cand_q <= cand_q + 1'b1;
      div_q  <= FIRST_PRIME;
      mult_q <= {1'b0, FIRST_PRIME};
    end else if (cmd_i.next_div) begin
      div_q  <= div_inc;
      mult_q <= {1'b0, div_inc};
    end else if (cmd_i.add_div) begin
      mult_q <= mult_q + {1'b0, div_q};
    end
    if (cmd_i.take_prime) begin
      pend_q <= cand_q;
    end
    if (cmd_i.emit_final) begin
      prime_q <= pend_v_q ? pend_q : '0;
      found_q <= pend_v_q;
      last_q  <= 1'b1;
    end else if (cmd_i.take_prime) begin
      prime_q <= pend_q;
      found_q <= 1'b1;
      last_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit_final | (cmd_i.take_prime & pend_v_q);
      if (cmd_i.load) pend_v_q <= 1'b0;
      else if (cmd_i.take_prime) pend_v_q <= 1'b1;
    end
  end

  assign status_o.lim_lt2      = (lim_q < FIRST_PRIME);
  assign status_o.div_eq_cand  = (div_q == cand_q);
  assign status_o.mult_eq_cand = (mult_q == cand_ext);
  assign status_o.mult_gt_cand = (mult_q > cand_ext);
  assign status_o.cand_eq_lim  = (cand_q == lim_q);

  assign result_valid_o = valid_q;
  assign prime_o        = prime_q;
  assign found_o        = found_q;
  assign last_o         = last_q;

endmodule

### src/prime_lister_trial_division_unit.sv
// ----------------------------------------------------------------------------
// prime_lister_trial_division_unit
// Lists every prime from 2 up to a requested limit by trial division.
// ----------------------------------------------------------------------------
// Usage:
//   Input transaction: drive limit_i and raise start while busy is low; the
//   limit is taken at that edge and saturates to MAX_LIMIT.
//   Results: result_valid_o pulses for one cycle per prime with prime_o,
//   found_o = 1; the last prime of the run has last_o = 1. A limit below 2
//   gives one result with prime_o = 0, found_o = 0, last_o = 1.
//   Each result is held back until the next prime is found, so last_o is
//   known; the final one is shown as busy falls.
// Operation:
//   The divisibility test walks multiples of each trial divisor with one
//   add and compare per cycle. A prime candidate c is walked against every
//   divisor d < c until the divisor reaches c; a composite stops at its
//   smallest factor. A limit below 2 tests no candidate.
//   One request is in work at a time; busy stays high until the final
//   result is issued.
// Reset: clears the sequencer, the pending-prime flag and the result strobe; no clearing pass.
// The receiver cannot stall: every strobe is a taken transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_lister_trial_division_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [pltd_pkg::CAND_W-1:0] limit_i,
  output logic                        result_valid_o,
  output logic [pltd_pkg::CAND_W-1:0] prime_o,
  output logic                        found_o,
  output logic                        last_o
);
  import pltd_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    start_ok;

  assign start_ok = start & ~busy;

  pltd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_ok),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  pltd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .limit_i        (limit_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .prime_o        (prime_o),
    .found_o        (found_o),
    .last_o         (last_o)
  );

`include "prime_lister_trial_division_unit_assert.svh"

  `PLTD_ASSERT_NXT(a_start_busy, start_ok, busy, "accepted transaction did not raise busy")
  `PLTD_ASSERT_IMP(a_last_idle, result_valid_o && last_o, !busy, "busy after final result")
  `PLTD_ASSERT_IMP(a_empty_last, result_valid_o && !found_o, last_o && prime_o == '0,
                   "empty result malformed")
  `PLTD_ASSERT_IMP(a_prime_min, result_valid_o && found_o, prime_o >= FIRST_PRIME,
                   "prime below two")
  `PLTD_ASSERT_IMP(a_mid_busy, result_valid_o && !last_o, busy, "run ended without last")

endmodule

### dv/prime_lister_trial_division_unit_tb.sv
// ----------------------------------------------------------------------------
// prime_lister_trial_division_unit_tb
// Self-checking bench for the trial-division prime lister. Limits are sent as
// start/busy transactions in bursts with random gaps. Every accepted limit is
// expanded into its expected list of primes, and each result strobe is checked
// in order against that list. Runs cover empty runs, small and top limits,
// then a random mix that is weighted toward cheap limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_lister_trial_division_unit_tb;

  localparam int unsigned TIMEOUT_CYCLES = 20_000_000;
  localparam int unsigned TAIL_CYCLES    = 50;

  typedef logic [pltd_pkg::CAND_W-1:0] lim_t;

  typedef struct packed {
    logic [pltd_pkg::CAND_W-1:0] prime;
    logic                        found;
    logic                        last;
  } prime_rec_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic [pltd_pkg::CAND_W-1:0] limit_i;
  logic                        result_valid_o;
  logic [pltd_pkg::CAND_W-1:0] prime_o;
  logic                        found_o;
  logic                        last_o;

  prime_rec_t  primes_due[$];
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned burst_left;

  prime_lister_trial_division_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .limit_i        (limit_i),
    .result_valid_o (result_valid_o),
    .prime_o        (prime_o),
    .found_o        (found_o),
    .last_o         (last_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Expand one accepted limit into the primes it should produce.
  function automatic void queue_primes(input logic [pltd_pkg::CAND_W-1:0] lim_in);
    int         lim;
    bit         composite;
    prime_rec_t rec;
    lim = int'(lim_in);
    if (lim > int'(pltd_pkg::MAX_LIMIT)) begin
      lim = int'(pltd_pkg::MAX_LIMIT);
    end
    if (lim < int'(pltd_pkg::FIRST_PRIME)) begin
      rec.prime = '0;
      rec.found = 1'b0;
      rec.last  = 1'b1;
      primes_due.push_back(rec);
    end else begin
      for (int c = int'(pltd_pkg::FIRST_PRIME); c <= lim; c++) begin
        composite = 1'b0;
        for (int d = int'(pltd_pkg::FIRST_PRIME); d < c; d++) begin
          if (c % d == 0) begin
            composite = 1'b1;
          end
        end
        if (!composite) begin
          rec.prime = c[pltd_pkg::CAND_W-1:0];
          rec.found = 1'b1;
          rec.last  = 1'b0;
          primes_due.push_back(rec);
        end
      end
      primes_due[primes_due.size()-1].last = 1'b1;
    end
  endfunction

  // One input transaction; start is left high so back-to-back sends need no drop.
  task automatic send_limit(input logic [pltd_pkg::CAND_W-1:0] lim);
    @(negedge clk_i);
    start   <= 1'b1;
    limit_i <= lim;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
    queue_primes(lim);
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk_i);
        start   <= 1'b0;
        limit_i <= lim_t'($urandom);
        repeat ($urandom_range(0, 20)) begin
          @(negedge clk_i);
          limit_i <= lim_t'($urandom);
        end
      end
    end
  endtask

  task automatic test_empty_runs();
    send_limit(8'd0);
    send_limit(8'd1);
    send_limit(8'd0);
    send_limit(8'd2);
    send_limit(8'd1);
  endtask

  task automatic test_small_limits();
    send_limit(8'd3);
    send_limit(8'd4);
    send_limit(8'd5);
    send_limit(8'd6);
    send_limit(8'd7);
    send_limit(8'd9);
    send_limit(8'd13);
    send_limit(8'd16);
    send_limit(8'd31);
    send_limit(8'd32);
    send_limit(8'd64);
  endtask

  task automatic test_top_limits();
    send_limit(8'd127);
    send_limit(8'd128);
    send_limit(8'd251);
    send_limit(8'd255);
  endtask

  // Mostly cheap limits; only a few reach the top of the range.
  task automatic test_random_mix();
    int unsigned sel;
    logic [pltd_pkg::CAND_W-1:0] lim;
    for (int i = 0; i < 100; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        lim = lim_t'($urandom_range(128, 255));
      end else if (sel < 20) begin
        lim = lim_t'($urandom_range(41, 127));
      end else if (sel < 30) begin
        lim = lim_t'($urandom_range(0, 1));
      end else begin
        lim = lim_t'($urandom_range(2, 40));
      end
      send_limit(lim);
    end
  endtask

  always @(posedge clk_i) begin
    prime_rec_t exp_rec;
    if (rst_ni && result_valid_o) begin
      if (primes_due.size() == 0) begin
        $display("%0t: unexpected result prime=%0d found=%0b last=%0b",
                 $time, prime_o, found_o, last_o);
        err_cnt++;
      end else begin
        exp_rec = primes_due.pop_front();
        if (prime_o !== exp_rec.prime) begin
          $display("%0t: prime mismatch expected=%0d actual=%0d",
                   $time, exp_rec.prime, prime_o);
          err_cnt++;
        end
        if (found_o !== exp_rec.found) begin
          $display("%0t: found mismatch expected=%0b actual=%0b",
                   $time, exp_rec.found, found_o);
          err_cnt++;
        end
        if (last_o !== exp_rec.last) begin
          $display("%0t: last mismatch expected=%0b actual=%0b",
                   $time, exp_rec.last, last_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < TIMEOUT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t: timeout, %0d results still due", $time, primes_due.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    err_cnt    = 0;
    burst_left = 1;
    rst_ni     = 1'b0;
    start      = 1'b0;
    limit_i    = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_runs();
    test_small_limits();
    test_top_limits();
    test_random_mix();

    @(negedge clk_i);
    start <= 1'b0;
    while (primes_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/pltd_pkg.sv
src/pltd_ctrl.sv
src/pltd_dp.sv
src/prime_lister_trial_division_unit.sv
dv/prime_lister_trial_division_unit_tb.sv
